[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the dynamics block.
// Needs a signal named clk and a signal named rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, off while reset is high.
`define DCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising edge, off while reset is high.
`define DCL_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[hw/rtl/dcl_pkg.sv]
// Package of the dynamics compressor/limiter: item types, register indexes,
// sequencer states, log2/exp2 tables and fixed-point constants. No dependencies.
package dcl_pkg;

  localparam int MAX_LOOKAHEAD_DEF = 512;
  localparam int CLIP_HOLD_DEF     = 12000;

  localparam int CFG_DW = 17;
  localparam int CFG_IW = 3;

  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [21:0] LOG2_PER_DB = 22'd2786635;
  localparam logic [16:0] UNITY       = 17'd65536;
  localparam logic [16:0] GAIN_FLOOR  = 17'd7;
  localparam logic [14:0] METER_MAX   = 15'd20480;
  localparam logic [16:0] FULL_SCALE  = 17'd32768;
  localparam logic [16:0] MAG_MAX     = 17'd131071;

  localparam logic [16:0] LOG_TAB [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536};

  localparam logic [17:0] EXP_TAB [17] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120193, 18'd125515, 18'd131072};

  typedef enum logic [CFG_IW-1:0] {
    REG_MODE, REG_BYPASS, REG_THRESHOLD, REG_RATIO, REG_ATTACK, REG_RELEASE,
    REG_HOLD, REG_LOOKAHEAD
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MEM, S_PEAK, S_PEAK_APP, S_LVL, S_LOG_MUL, S_LOG_SUM,
    S_DB_MUL, S_DB_CHK, S_ATT_MUL, S_ATT_SET, S_EXP_MUL, S_EXP_CHK, S_EXP_DEC,
    S_EXP_SUM, S_GAIN_MUL, S_GAIN_SET, S_APPLY_MUL, S_APPLY_SET, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [17:0] sample_in;
    logic [16:0]        partner_gain;
    logic               clear_meter;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] sample_out;
    logic [16:0]        applied_gain;
    logic [16:0]        target_gain;
    logic [14:0]        reduction_meter;
    logic               clipping;
  } out_item_t;

endpackage

[hw/rtl/dcl_if.sv]
// Valid/ready channels of the dynamics block: input items and result items.
// Depends on dcl_pkg for the payload types.
interface dcl_in_if import dcl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcl_out_if import dcl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dynamics_compressor_limiter_core.sv]
// Top level of the dynamics compressor/limiter: sequencer, one shared multiplier,
// look-ahead delay memory. Depends on dcl_pkg, dcl_if.sv and assert_macros.svh.
//
// Usage: one audio sample enters per item on the samples channel (sample, the
// partner channel's gain and a meter clear flag) and one result item leaves on
// the results channel. The user must write registers through cfg_we/cfg_idx/cfg_data
// only while the block is idle; the block itself does not enforce it.
// Each item walks a sequencer that feeds a single 25x25 multiplier, one product
// per cycle. Bypass takes the short path from accept to result, and the full path
// runs the gain computer, the smoothing and the meter log through the multiplier
// chain of log2, dB, slope, exp2, smoothing and apply.
// The next item is taken in the cycle after the result leaves.
// samples.ready is high only while the block is idle; results.valid holds the
// result until results.ready is seen, and no new item is taken before then.
// After reset the delay memory is cleared, one entry a cycle, over all MAX_LOOKAHEAD
// entries; samples.ready stays low during that pass. Reset also sets unity gain,
// an empty peak detector, meter and clip state, and the register defaults.
module dynamics_compressor_limiter_core import dcl_pkg::*; #(
  parameter int MAX_LOOKAHEAD     = MAX_LOOKAHEAD_DEF,
  parameter int CLIP_HOLD_SAMPLES = CLIP_HOLD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dcl_in_if.sink            samples,
  dcl_out_if.source         results,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LW = ($clog2(MAX_LOOKAHEAD + 1) > 10) ? $clog2(MAX_LOOKAHEAD + 1) : 10;

  // Configuration registers.
  logic               mode, bypass;
  logic signed [15:0] threshold_db;
  logic [16:0]        ratio_slope;
  logic [15:0]        attack_coeff, release_coeff, hold_samples;
  logic [9:0]         lookahead_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= 1'b0;
      bypass           <= 1'b0;
      threshold_db     <= -16'sd256;
      ratio_slope      <= 17'd49152;
      attack_coeff     <= 16'd0;
      release_coeff    <= 16'd65000;
      hold_samples     <= 16'd480;
      lookahead_length <= 10'd480;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MODE:      mode             <= cfg_data[0];
        REG_BYPASS:    bypass           <= cfg_data[0];
        REG_THRESHOLD: threshold_db     <= $signed(cfg_data[15:0]);
        REG_RATIO:     ratio_slope      <= cfg_data;
        REG_ATTACK:    attack_coeff     <= cfg_data[15:0];
        REG_RELEASE:   release_coeff    <= cfg_data[15:0];
        REG_HOLD:      hold_samples     <= cfg_data[15:0];
        REG_LOOKAHEAD: lookahead_length <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Item and datapath registers.
  logic signed [17:0] x_r, work_r, y_r;
  logic [16:0]        mag_r, partner_r, target_r, over_r, att_r;
  logic               clr_r, la_r, log_meter;
  logic [22:0]        exp_a;
  logic signed [21:0] lg;
  logic [AW-1:0]      ptr, clr_idx;
  logic [16:0]        peak, sg;
  logic [15:0]        hold, clip_hold;
  logic [1:0]         clip_run;
  logic [14:0]        meter;

  // Shared multiplier.
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] p;

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // Look-ahead delay memory.
  logic [17:0]   mem [MAX_LOOKAHEAD];
  logic [17:0]   mem_rd, mem_wdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rd <= mem[mem_addr];
  end

  // Delay pointer arithmetic.
  logic [LW-1:0] len_ext, len_sat, ptr_inc;
  logic [AW-1:0] ptr_eff, ptr_new;

  always_comb begin
    len_ext = LW'(lookahead_length);
    len_sat = (len_ext > LW'(MAX_LOOKAHEAD)) ? LW'(MAX_LOOKAHEAD) : len_ext;
    ptr_eff = (LW'(ptr) >= len_sat) ? '0 : ptr;
    ptr_inc = LW'(ptr_eff) + LW'(1);
    ptr_new = (ptr_inc >= len_sat) ? '0 : ptr_inc[AW-1:0];
  end

  // Input magnitude, saturated.
  logic [17:0] in_abs;
  logic [16:0] in_mag;
  always_comb begin
    in_abs = samples.data.sample_in[17] ? 18'(-samples.data.sample_in)
                                        : 18'(samples.data.sample_in);
    in_mag = (in_abs > 18'(MAG_MAX)) ? MAG_MAX : in_abs[16:0];
  end

  logic signed [17:0] work;
  assign work = la_r ? $signed(mem_rd) : x_r;

  // Log2 of the peak level or of the smoothed gain.
  logic [16:0] log_src;
  logic [4:0]  log_e;
  logic [32:0] log_norm;
  logic [3:0]  lidx;
  logic [11:0] lr;
  logic [20:0] log_val;
  always_comb begin
    log_src = log_meter ? sg : peak;
    log_e   = 5'd0;
    for (int i = 1; i < 17; i++) begin
      if (log_src[i]) log_e = 5'(i);
    end
    log_norm = 33'(log_src) << (5'd16 - log_e);
    lidx     = log_norm[15:12];
    lr       = log_norm[11:0];
    log_val  = {log_e, 16'd0} + 21'(LOG_TAB[5'(lidx)]) + 21'(p[28:12]);
  end

  // dB compare and meter value.
  logic signed [25:0] db_v;
  logic signed [26:0] over;
  logic [25:0]        red;
  logic [14:0]        red_c;
  always_comb begin
    db_v  = 26'(p >>> 24);
    over  = 27'(db_v) - 27'(threshold_db);
    red   = p[49:24];
    red_c = (red > 26'(METER_MAX)) ? METER_MAX : red[14:0];
  end

  // Exp2 decode.
  logic [6:0]  ip;
  logic [15:0] fp, q;
  logic [4:0]  eidx;
  logic [18:0] exp_sum;
  logic [16:0] exp_tgt;
  always_comb begin
    ip      = exp_a[22:16];
    fp      = exp_a[15:0];
    q       = 16'(17'h10000 - 17'(fp));
    eidx    = 5'(q[15:12]);
    exp_sum = 19'(EXP_TAB[eidx]) + 19'(p[29:12]);
    exp_tgt = 17'(exp_sum >> (ip + 7'd1));
  end

  // Gain smoothing and application.
  logic [16:0]        g_lim, g_diff;
  logic               g_down;
  logic [15:0]        g_coeff;
  logic [17:0]        g_new;
  logic [16:0]        g_clamped;
  logic signed [33:0] y_full;
  logic signed [17:0] y_clamped;
  always_comb begin
    g_lim   = (target_r < partner_r) ? target_r : partner_r;
    g_down  = g_lim < sg;
    g_coeff = g_down ? attack_coeff : release_coeff;
    g_diff  = g_down ? sg - g_lim : g_lim - sg;
    g_new   = g_down ? 18'(g_lim) + 18'(p[32:16]) : 18'(g_lim) - 18'(p[32:16]);
    if (g_new > 18'(UNITY)) g_clamped = UNITY;
    else if (g_new < 18'(GAIN_FLOOR)) g_clamped = GAIN_FLOOR;
    else g_clamped = g_new[16:0];
    y_full = 34'(p >>> 16);
    if (y_full > 34'sd32768) y_clamped = 18'sd32768;
    else if (y_full < -34'sd32768) y_clamped = -18'sd32768;
    else y_clamped = y_full[17:0];
  end

  logic [1:0] run_next;
  assign run_next = (clip_run < 2'd3) ? clip_run + 2'd1 : clip_run;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:     if (clr_idx == AW'(MAX_LOOKAHEAD - 1)) state_next = S_IDLE;
      S_IDLE:      if (samples.valid) state_next = S_MEM;
      S_MEM:       state_next = S_PEAK;
      S_PEAK: begin
        if (bypass) state_next = S_OUT;
        else if (mag_r > peak || hold != 16'd0) state_next = S_LVL;
        else state_next = S_PEAK_APP;
      end
      S_PEAK_APP:  state_next = S_LVL;
      S_LVL:       state_next = (peak == 17'd0) ? S_GAIN_MUL : S_LOG_MUL;
      S_LOG_MUL:   state_next = S_LOG_SUM;
      S_LOG_SUM:   state_next = S_DB_MUL;
      S_DB_MUL:    state_next = S_DB_CHK;
      S_DB_CHK: begin
        if (log_meter) state_next = S_APPLY_MUL;
        else if (over <= 27'sd0) state_next = S_GAIN_MUL;
        else state_next = S_ATT_MUL;
      end
      S_ATT_MUL:   state_next = S_ATT_SET;
      S_ATT_SET:   state_next = S_EXP_MUL;
      S_EXP_MUL:   state_next = S_EXP_CHK;
      S_EXP_CHK:   state_next = S_EXP_DEC;
      S_EXP_DEC: begin
        state_next = (fp == 16'd0 || ip >= 7'd17) ? S_GAIN_MUL : S_EXP_SUM;
      end
      S_EXP_SUM:   state_next = S_GAIN_MUL;
      S_GAIN_MUL:  state_next = S_GAIN_SET;
      S_GAIN_SET:  state_next = (g_clamped < UNITY) ? S_LOG_MUL : S_APPLY_MUL;
      S_APPLY_MUL: state_next = S_APPLY_SET;
      S_APPLY_SET: state_next = S_OUT;
      S_OUT:       if (results.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, memory port, handshakes.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_addr  = ptr_eff;
    mem_wdata = x_r;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx;
        mem_wdata = '0;
      end
      S_MEM: mem_we = la_r;
      S_PEAK: begin
        mul_a = 25'(release_coeff);
        mul_b = 25'(peak - mag_r);
      end
      S_LOG_MUL: begin
        mul_a = 25'(LOG_TAB[5'(lidx) + 5'd1] - LOG_TAB[5'(lidx)]);
        mul_b = 25'(lr);
      end
      S_DB_MUL: begin
        mul_a = 25'(lg);
        mul_b = 25'(DB_PER_LOG2);
      end
      S_ATT_MUL: begin
        mul_a = 25'(over_r);
        mul_b = 25'(mode ? ratio_slope : UNITY);
      end
      S_EXP_MUL: begin
        mul_a = 25'(att_r);
        mul_b = 25'(LOG2_PER_DB);
      end
      S_EXP_DEC: begin
        mul_a = 25'(EXP_TAB[eidx + 5'd1] - EXP_TAB[eidx]);
        mul_b = 25'(q[11:0]);
      end
      S_GAIN_MUL: begin
        mul_a = 25'(g_coeff);
        mul_b = 25'(g_diff);
      end
      S_APPLY_MUL: begin
        mul_a = 25'(work_r);
        mul_b = 25'(sg);
      end
      default: ;
    endcase
  end

  assign samples.ready = (state == S_IDLE);
  assign results.valid = (state == S_OUT);
  assign results.data.sample_out      = y_r;
  assign results.data.applied_gain    = sg;
  assign results.data.target_gain     = target_r;
  assign results.data.reduction_meter = meter;
  assign results.data.clipping        = (clip_hold != 16'd0);

  // Datapath and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      ptr       <= '0;
      peak      <= '0;
      hold      <= '0;
      sg        <= UNITY;
      meter     <= '0;
      clip_run  <= '0;
      clip_hold <= '0;
      log_meter <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr_idx <= clr_idx + AW'(1);
        S_IDLE: begin
          if (samples.valid) begin
            x_r       <= samples.data.sample_in;
            partner_r <= samples.data.partner_gain;
            clr_r     <= samples.data.clear_meter;
            mag_r     <= in_mag;
            la_r      <= !mode && (len_sat != '0);
          end
        end
        S_MEM: begin
          if (la_r) ptr <= ptr_new;
          if (clip_hold != 16'd0) clip_hold <= clip_hold - 16'd1;
        end
        S_PEAK: begin
          work_r <= work;
          if (bypass) begin
            y_r      <= work;
            target_r <= UNITY;
            if (mag_r >= FULL_SCALE) begin
              clip_run <= run_next;
              if (run_next == 2'd3) clip_hold <= 16'(CLIP_HOLD_SAMPLES);
            end else begin
              clip_run <= 2'd0;
            end
          end else if (mag_r > peak) begin
            peak <= mag_r;
            hold <= hold_samples;
          end else if (hold != 16'd0) begin
            hold <= hold - 16'd1;
          end
        end
        S_PEAK_APP: peak <= mag_r + p[32:16];
        S_LVL: begin
          log_meter <= 1'b0;
          if (peak == 17'd0) target_r <= UNITY;
        end
        S_LOG_SUM: begin
          lg <= log_meter ? 22'sd1048576 - $signed(22'(log_val))
                          : $signed(22'(log_val)) - 22'sd983040;
        end
        S_DB_CHK: begin
          if (log_meter) begin
            if (red_c > meter) meter <= red_c;
          end else begin
            over_r <= over[16:0];
            if (over <= 27'sd0) target_r <= UNITY;
          end
        end
        S_ATT_SET: att_r <= p[32:16];
        S_EXP_CHK: exp_a <= p[38:16];
        S_EXP_DEC: begin
          if (fp == 16'd0) target_r <= (ip >= 7'd17) ? 17'd0 : (UNITY >> ip);
          else if (ip >= 7'd17) target_r <= 17'd0;
        end
        S_EXP_SUM: target_r <= exp_tgt;
        S_GAIN_SET: begin
          sg        <= g_clamped;
          log_meter <= 1'b1;
        end
        S_APPLY_SET: y_r <= y_clamped;
        S_OUT: if (results.ready && clr_r) meter <= '0;
        default: ;
      endcase
      if (cfg_we && cfg_reg_t'(cfg_idx) == REG_BYPASS && !cfg_data[0]) begin
        clip_run  <= '0;
        clip_hold <= '0;
      end
    end
  end

  `DCL_ASSERT(a_gain_range, sg >= GAIN_FLOOR && sg <= UNITY, "smoothed gain out of range")
  `DCL_ASSERT(a_meter_range, meter <= METER_MAX, "reduction meter above its ceiling")
  `DCL_ASSERT_IMP(a_one_item, samples.ready, !results.valid, "input taken while a result waits")
  `DCL_ASSERT_IMP(a_ret_idle, results.valid && results.ready, ##1 samples.ready, "no idle after result")

endmodule
